FILE: rtl/rsac_pkg.sv
// Shared types, constants and command codes of the radiometer step averager.
package rsac_pkg;

    localparam int CHANNELS_DEF   = 32;
    localparam int MAX_SWEEPS_DEF = 1024;
    localparam int MAX_COUNT_DEF  = 65535;

    localparam int NUM_KINDS = 6;

    localparam logic [2:0] KIND_OFF_I  = 3'd0;
    localparam logic [2:0] KIND_GAIN_I = 3'd1;
    localparam logic [2:0] KIND_OFF_Q  = 3'd2;
    localparam logic [2:0] KIND_GAIN_Q = 3'd3;
    localparam logic [2:0] KIND_KQI    = 3'd4;
    localparam logic [2:0] KIND_KIQ    = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic CFG_NULL_I = 1'b0;
    localparam logic CFG_NULL_Q = 1'b1;

    localparam logic LANE_I = 1'b0;
    localparam logic LANE_Q = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [23:0] sample_i;
        logic signed [23:0] sample_q;
        logic [4:0]         channel_index;
        logic [31:0]        elapsed_time;
        logic [47:0]        clock_time;
        logic [4:0]         coef_channel;
        logic [2:0]         coef_kind;
        logic signed [31:0] coef_value;
    } t_in;

    typedef struct packed {
        logic [4:0]         step_channel;
        logic [9:0]         sweep_index;
        logic signed [23:0] mean_i;
        logic signed [23:0] mean_q;
        logic signed [31:0] bright_temp_i;
        logic signed [31:0] bright_temp_q;
        logic [31:0]        mean_elapsed;
        logic [47:0]        mean_clock;
        logic               invalid;
    } t_out;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_EMPTY,
        CMD_READ,
        CMD_DIV_START,
        CMD_DIV_STORE,
        CMD_MUL_KK,
        CMD_D16,
        CMD_SINGULAR,
        CMD_MUL_K,
        CMD_NUM,
        CMD_MUL_HI,
        CMD_MUL_LO,
        CMD_BRIGHT,
        CMD_EMIT
    } t_cmd;

    typedef enum logic [2:0] {
        JOB_MI,
        JOB_MQ,
        JOB_ME,
        JOB_MC,
        JOB_X
    } t_job;

    typedef struct packed {
        t_cmd       cmd;
        t_job       job;
        logic       lane;
        logic [2:0] kind;
    } t_ctl;

    typedef struct packed {
        logic item_change;
        logic count_zero;
        logic d16_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/radiometer_step_average_calibrate.sv
// Top level of the radiometer step averager and calibrator.
//
// Input channel (i_valid / o_stall / i_data): a transaction is either a
// sample record or a coefficient load. Records of an unchanged channel are
// summed in the accepted cycle; loads write the coefficient memory at once.
// Such transactions stream back to back.
// A record with a new channel closes the step and is dropped. The block then
// stalls its input while it averages and calibrates: four mean divisions and
// two crosstalk divisions go through one shared restoring divider that makes
// one quotient bit per cycle (74 bits), plus coefficient reads, multiplies and
// emit. The input stays stalled until the result is emitted.
// Output channel (o_valid / i_stall / o_data): one transaction per closed
// step, held in an output register; a stalled result holds steady, and the
// block keeps accepting samples while it waits, only the next closing step
// holds in its final state until the register frees.
// Configuration writes (null offsets) land on the edge with i_cfg_wr_en high.
// Reset clears sums, count, channel, sweep number and offsets; coefficient
// memory is not cleared and must be loaded before use.
module radiometer_step_average_calibrate #(
    parameter int CHANNELS   = rsac_pkg::CHANNELS_DEF,
    parameter int MAX_SWEEPS = rsac_pkg::MAX_SWEEPS_DEF,
    parameter int MAX_COUNT  = rsac_pkg::MAX_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rsac_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output rsac_pkg::t_out o_data,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_index,
    input  logic [23:0]    i_cfg_data
);
    import rsac_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer: owns the input handshake and the order of datapath steps
    rsac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // datapath: sums, memory, divider, multiplies and output register
    rsac_datapath #(
        .CHANNELS   (CHANNELS),
        .MAX_SWEEPS (MAX_SWEEPS),
        .MAX_COUNT  (MAX_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: rtl/rsac_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rsac_div #(
    parameter int DVD_W = 74,
    parameter int DVS_W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/rsac_datapath.sv
// Step accumulators, coefficient memory, divider, multiplier and result register.
module rsac_datapath #(
    parameter int CHANNELS   = rsac_pkg::CHANNELS_DEF,
    parameter int MAX_SWEEPS = rsac_pkg::MAX_SWEEPS_DEF,
    parameter int MAX_COUNT  = rsac_pkg::MAX_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsac_pkg::t_ctl   i_ctl,
    output rsac_pkg::t_sts   o_sts,
    input  rsac_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output rsac_pkg::t_out   o_data,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_index,
    input  logic [23:0]      i_cfg_data
);
    import rsac_pkg::*;

    localparam int CW     = $clog2(MAX_COUNT + 1);
    localparam int SI_W   = 24 + CW;
    localparam int SE_W   = 32 + CW;
    localparam int SC_W   = 48 + CW;
    localparam int SW_W   = $clog2(MAX_SWEEPS);
    localparam int DEPTH  = NUM_KINDS * CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DVD_W  = (SC_W > 74) ? SC_W : 74;
    localparam int DVS_W  = (CW > 48) ? CW : 48;

    localparam logic signed [65:0] T_MAX = 66'sd2147483647;
    localparam logic signed [65:0] T_MIN = -66'sd2147483648;

    // step state
    logic signed [23:0]   r_null_i, r_null_q;
    logic signed [SI_W-1:0] r_sum_i, r_sum_q;
    logic [SE_W-1:0]      r_sum_e;
    logic [SC_W-1:0]      r_sum_c;
    logic [CW-1:0]        r_count;
    logic [4:0]           r_prev;
    logic [4:0]           r_new_ch;
    logic [SW_W-1:0]      r_sweep;

    // coefficient store
    logic signed [31:0]   r_mem [DEPTH];
    logic [31:0]          r_mem_q;
    logic                 r_rd_vld;
    logic [2:0]           r_rd_kind;
    logic signed [31:0]   r_coef [NUM_KINDS];

    // working registers
    logic signed [23:0]   r_mi, r_mq;
    logic [31:0]          r_me;
    logic [47:0]          r_mc;
    logic signed [63:0]   r_prod;
    logic signed [48:0]   r_prod2;
    logic signed [47:0]   r_d16;
    logic signed [57:0]   r_num;
    logic signed [48:0]   r_x;
    logic signed [31:0]   r_ti, r_tq;
    logic                 r_bad;
    logic                 r_div_neg;
    logic                 r_out_vld;
    t_out                 r_out;

    logic                 accept, emit, ch_ok, mem_we, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [DVD_W-1:0]     dvd, quot;
    logic [DVS_W-1:0]     dvs;
    logic                 dneg, div_done;
    logic [SI_W-1:0]      mag_si, mag_sq;
    logic [57:0]          mag_num;
    logic [47:0]          mag_d16;
    logic                 x_sat;
    logic [48:0]          x_mag;
    logic signed [24:0]   di, dq, d_own, d_other;
    logic signed [31:0]   k_sel, b_sel, a_sel;
    logic signed [63:0]   prod_kk;
    logic signed [56:0]   prod_k;
    logic signed [32:0]   xh;
    logic signed [16:0]   xl_s;
    logic signed [64:0]   prod_hi;
    logic signed [48:0]   prod_lo;
    logic signed [48:0]   lo_sh;
    logic signed [65:0]   v16, v16_adj, v16_sh;
    logic signed [63:0]   num64;
    logic signed [65:0]   t_sum;
    logic signed [31:0]   t_sat;
    logic                 out_free;

    assign accept   = i_ctl.cmd == CMD_ACCEPT;
    assign emit     = i_ctl.cmd == CMD_EMIT;
    assign ch_ok    = int'(r_prev) < CHANNELS;
    assign out_free = !r_out_vld || !i_stall;

    // coefficient memory
    assign mem_we  = accept && i_data.operation == OP_LOAD
                     && int'(i_data.coef_channel) < CHANNELS
                     && int'(i_data.coef_kind) < NUM_KINDS;
    assign wr_addr = ADDR_W'(int'(i_data.coef_kind) * CHANNELS + int'(i_data.coef_channel));
    assign rd_en   = i_ctl.cmd == CMD_READ && ch_ok;
    assign rd_addr = ADDR_W'(int'(i_ctl.kind) * CHANNELS + int'(r_prev));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_data.coef_value;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // divider operand selection
    assign mag_si  = r_sum_i[SI_W-1] ? SI_W'(-r_sum_i) : SI_W'(r_sum_i);
    assign mag_sq  = r_sum_q[SI_W-1] ? SI_W'(-r_sum_q) : SI_W'(r_sum_q);
    assign mag_num = r_num[57] ? 58'(-r_num) : 58'(r_num);
    assign mag_d16 = r_d16[47] ? 48'(-r_d16) : 48'(r_d16);

    always_comb begin
        dvd  = '0;
        dvs  = DVS_W'(r_count);
        dneg = 1'b0;
        unique case (i_ctl.job)
            JOB_MI: begin
                dvd  = DVD_W'(mag_si);
                dneg = r_sum_i[SI_W-1];
            end
            JOB_MQ: begin
                dvd  = DVD_W'(mag_sq);
                dneg = r_sum_q[SI_W-1];
            end
            JOB_ME: dvd = DVD_W'(r_sum_e);
            JOB_MC: dvd = DVD_W'(r_sum_c);
            JOB_X: begin
                dvd  = DVD_W'({mag_num, 16'h0000});
                dvs  = DVS_W'(mag_d16);
                dneg = r_num[57] ^ r_d16[47];
            end
            default: dvd = '0;
        endcase
    end

    rsac_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.cmd == CMD_DIV_START),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // quotient saturates at 2^47 in Q16.16
    assign x_sat = |quot[DVD_W-1:47];
    assign x_mag = x_sat ? {2'b01, 47'h0} : {2'b00, quot[46:0]};

    // calibration arithmetic
    assign di      = 25'(r_mi) - 25'(r_null_i);
    assign dq      = 25'(r_mq) - 25'(r_null_q);
    assign d_own   = (i_ctl.lane == LANE_Q) ? dq : di;
    assign d_other = (i_ctl.lane == LANE_Q) ? di : dq;
    assign k_sel   = (i_ctl.lane == LANE_Q) ? r_coef[KIND_KIQ] : r_coef[KIND_KQI];
    assign b_sel   = (i_ctl.lane == LANE_Q) ? r_coef[KIND_GAIN_Q] : r_coef[KIND_GAIN_I];
    assign a_sel   = (i_ctl.lane == LANE_Q) ? r_coef[KIND_OFF_Q] : r_coef[KIND_OFF_I];

    assign prod_kk = r_coef[KIND_KQI] * r_coef[KIND_KIQ];
    assign prod_k  = k_sel * d_other;
    assign xh      = r_x[48:16];
    assign xl_s    = {1'b0, r_x[15:0]};
    assign prod_hi = b_sel * xh;
    assign prod_lo = b_sel * xl_s;
    assign lo_sh   = r_prod2 >>> 16;

    // divisor 1 - kqi*kiq, truncated toward zero to Q16.16
    assign v16     = 66'sh1_0000_0000 - 66'(r_prod);
    assign v16_adj = v16 + (v16[65] ? 66'sd65535 : 66'sd0);
    assign v16_sh  = v16_adj >>> 16;

    assign num64   = (64'(d_own) <<< 16) - r_prod;

    assign t_sum   = 66'(r_prod) + 66'(lo_sh) + 66'(a_sel);
    always_comb begin
        priority if (t_sum > T_MAX) begin
            t_sat = 32'sh7FFF_FFFF;
        end else if (t_sum < T_MIN) begin
            t_sat = 32'sh8000_0000;
        end else begin
            t_sat = t_sum[31:0];
        end
    end

    // step state, configuration and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_i  <= '0;
            r_null_q  <= '0;
            r_sum_i   <= '0;
            r_sum_q   <= '0;
            r_sum_e   <= '0;
            r_sum_c   <= '0;
            r_count   <= '0;
            r_prev    <= '0;
            r_sweep   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.cmd == CMD_READ;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_NULL_I: r_null_i <= i_cfg_data;
                    CFG_NULL_Q: r_null_q <= i_cfg_data;
                    default:    r_null_i <= r_null_i;
                endcase
            end
            if (accept && i_data.operation == OP_SAMPLE
                && i_data.channel_index == r_prev && r_count < CW'(MAX_COUNT)) begin
                r_sum_i <= r_sum_i + SI_W'(i_data.sample_i);
                r_sum_q <= r_sum_q + SI_W'(i_data.sample_q);
                r_sum_e <= r_sum_e + SE_W'(i_data.elapsed_time);
                r_sum_c <= r_sum_c + SC_W'(i_data.clock_time);
                r_count <= r_count + CW'(1);
            end
            if (emit) begin
                if (r_new_ch < r_prev && r_sweep < SW_W'(MAX_SWEEPS - 1)) begin
                    r_sweep <= r_sweep + SW_W'(1);
                end
                r_sum_i <= '0;
                r_sum_q <= '0;
                r_sum_e <= '0;
                r_sum_c <= '0;
                r_count <= '0;
                r_prev  <= r_new_ch;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_coef[r_rd_kind] <= ch_ok ? $signed(r_mem_q) : 32'sd0;
        end
        r_rd_kind <= i_ctl.kind;
        unique case (i_ctl.cmd)
            CMD_ACCEPT: begin
                r_bad    <= 1'b0;
                r_new_ch <= i_data.channel_index;
            end
            CMD_EMPTY: begin
                r_mi  <= '0;
                r_mq  <= '0;
                r_me  <= '0;
                r_mc  <= '0;
                r_ti  <= '0;
                r_tq  <= '0;
                r_bad <= 1'b1;
            end
            CMD_DIV_START: r_div_neg <= dneg;
            CMD_DIV_STORE: begin
                unique case (i_ctl.job)
                    JOB_MI: r_mi <= r_div_neg ? -quot[23:0] : quot[23:0];
                    JOB_MQ: r_mq <= r_div_neg ? -quot[23:0] : quot[23:0];
                    JOB_ME: r_me <= quot[31:0];
                    JOB_MC: r_mc <= quot[47:0];
                    JOB_X:  r_x  <= r_div_neg ? -x_mag : x_mag;
                    default: r_me <= r_me;
                endcase
            end
            CMD_MUL_KK: r_prod <= prod_kk;
            CMD_D16:    r_d16  <= v16_sh[47:0];
            CMD_SINGULAR: begin
                r_ti  <= '0;
                r_tq  <= '0;
                r_bad <= 1'b1;
            end
            CMD_MUL_K:  r_prod  <= 64'(prod_k);
            CMD_NUM:    r_num   <= num64[57:0];
            CMD_MUL_HI: r_prod  <= prod_hi[63:0];
            CMD_MUL_LO: r_prod2 <= prod_lo;
            CMD_BRIGHT: begin
                if (i_ctl.lane == LANE_Q) begin
                    r_tq <= t_sat;
                end else begin
                    r_ti <= t_sat;
                end
            end
            CMD_EMIT: begin
                r_out.step_channel  <= r_prev;
                r_out.sweep_index   <= 10'(r_sweep);
                r_out.mean_i        <= r_mi;
                r_out.mean_q        <= r_mq;
                r_out.bright_temp_i <= r_ti;
                r_out.bright_temp_q <= r_tq;
                r_out.mean_elapsed  <= r_me;
                r_out.mean_clock    <= r_mc;
                r_out.invalid       <= r_bad;
            end
            default: r_bad <= r_bad;
        endcase
    end

    assign o_sts.item_change = i_data.operation == OP_SAMPLE && i_data.channel_index != r_prev;
    assign o_sts.count_zero  = r_count == '0;
    assign o_sts.d16_zero    = r_d16 == '0;
    assign o_sts.div_done    = div_done;
    assign o_sts.out_free    = out_free;

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

FILE: rtl/rsac_ctrl.sv
// Sequencer that steps the datapath through averaging and calibration.
module rsac_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rsac_pkg::t_sts i_sts,
    output rsac_pkg::t_ctl o_ctl
);
    import rsac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EMPTY,
        S_READ,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL_KK,
        S_D16,
        S_CHK_D,
        S_SINGULAR,
        S_MUL_K,
        S_NUM,
        S_MUL_HI,
        S_MUL_LO,
        S_BRIGHT,
        S_EMIT
    } t_state;

    t_state     r_state;
    t_job       r_job;
    logic       r_lane;
    logic [2:0] r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_MI;
            r_lane  <= LANE_I;
            r_kind  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_sts.item_change) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_kind <= '0;
                    r_state <= i_sts.count_zero ? S_EMPTY : S_READ;
                end
                S_EMPTY: r_state <= S_EMIT;
                S_READ: begin
                    if (r_kind == KIND_KIQ) begin
                        r_job   <= JOB_MI;
                        r_state <= S_DIV_GO;
                    end else begin
                        r_kind <= r_kind + 3'd1;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_sts.div_done) begin
                        unique case (r_job)
                            JOB_MI: begin
                                r_job   <= JOB_MQ;
                                r_state <= S_DIV_GO;
                            end
                            JOB_MQ: begin
                                r_job   <= JOB_ME;
                                r_state <= S_DIV_GO;
                            end
                            JOB_ME: begin
                                r_job   <= JOB_MC;
                                r_state <= S_DIV_GO;
                            end
                            JOB_MC:  r_state <= S_MUL_KK;
                            JOB_X:   r_state <= S_MUL_HI;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL_KK: r_state <= S_D16;
                S_D16:    r_state <= S_CHK_D;
                S_CHK_D: begin
                    r_lane  <= LANE_I;
                    r_state <= i_sts.d16_zero ? S_SINGULAR : S_MUL_K;
                end
                S_SINGULAR: r_state <= S_EMIT;
                S_MUL_K:    r_state <= S_NUM;
                S_NUM: begin
                    r_job   <= JOB_X;
                    r_state <= S_DIV_GO;
                end
                S_MUL_HI: r_state <= S_MUL_LO;
                S_MUL_LO: r_state <= S_BRIGHT;
                S_BRIGHT: begin
                    if (r_lane == LANE_I) begin
                        r_lane  <= LANE_Q;
                        r_state <= S_MUL_K;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ctl.cmd  = CMD_NONE;
        o_ctl.job  = r_job;
        o_ctl.lane = r_lane;
        o_ctl.kind = r_kind;
        unique case (r_state)
            S_IDLE:     if (i_valid) o_ctl.cmd = CMD_ACCEPT;
            S_EMPTY:    o_ctl.cmd = CMD_EMPTY;
            S_READ:     o_ctl.cmd = CMD_READ;
            S_DIV_GO:   o_ctl.cmd = CMD_DIV_START;
            S_DIV_WAIT: if (i_sts.div_done) o_ctl.cmd = CMD_DIV_STORE;
            S_MUL_KK:   o_ctl.cmd = CMD_MUL_KK;
            S_D16:      o_ctl.cmd = CMD_D16;
            S_SINGULAR: o_ctl.cmd = CMD_SINGULAR;
            S_MUL_K:    o_ctl.cmd = CMD_MUL_K;
            S_NUM:      o_ctl.cmd = CMD_NUM;
            S_MUL_HI:   o_ctl.cmd = CMD_MUL_HI;
            S_MUL_LO:   o_ctl.cmd = CMD_MUL_LO;
            S_BRIGHT:   o_ctl.cmd = CMD_BRIGHT;
            S_EMIT:     if (i_sts.out_free) o_ctl.cmd = CMD_EMIT;
            default:    o_ctl.cmd = CMD_NONE;
        endcase
    end

    assign o_stall = r_state != S_IDLE;

endmodule
